// ===== hw/rtl/iiae_pkg.sv =====
// shared codes and types for the indexed integer array engine
// no dependencies
package iiae_pkg;

	typedef enum logic [2:0] {
		OP_INSERT    = 3'd0,
		OP_DELETE    = 3'd1,
		OP_SORT_UP   = 3'd2,
		OP_SORT_DOWN = 3'd3,
		OP_SEARCH    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD    = 7'b0000010,
		S_WAIT  = 7'b0000100,
		S_EXEC  = 7'b0001000,
		S_WB    = 7'b0010000,
		S_WB2   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

endpackage

// ===== hw/rtl/indexed_int_array_engine.sv =====
// indexed integer array engine top level: fsm plus one entry memory
// depends on iiae_pkg
//
// usage: drive operation, position and item_value and raise start while busy
// is low; that cycle accepts the transaction. busy stays high while the
// operation walks the memory and through the result cycle. one result
// (status, found, fill_count) appears for exactly one cycle with done high;
// the receiver cannot stall it.
// steps after the accepting edge, before the result with done high:
//   rejected index, full store, unused code, empty search, sort of < 2: none
//   insert or delete moving k entries: one read and one write per move, then a
//   write-back that updates the count (and stores the item on an insert)
//   search: one read and one compare per entry, until a match or the end
//   sort: an insertion sort; the worst case is a reversed full store
// throughput: the next transaction can be accepted in the cycle after done.
// the memory read is registered; every read is issued after the
// write it depends on has landed, so no forwarding is needed.
// reset clears the fill count and control; the memory content is not cleared,
// only entries below the count are ever used.
module indexed_int_array_engine #(
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           operation,
	input  logic [4:0]           position,
	input  logic signed [31:0]   item_value,
	output logic                 done,
	output logic [1:0]           status,
	output logic                 found,
	output logic [4:0]           fill_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata;

	iiae_pkg::state_t state_q;
	iiae_pkg::op_t    op_q;
	logic [CW-1:0] count_q, pos_q, i_q, j_q;
	logic [31:0]   val_q, v_q;
	logic [1:0]    status_q;
	logic          found_q, asc_q;

	logic [CW-1:0] pos_ext;
	logic          pos_big;
	logic          move;
	logic          last_i;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign pos_ext = CW'(position);
	assign pos_big = (CW < 5) ? (32'(position) > 32'(DEPTH)) : 1'b0;
	assign last_i = (i_q + CW'(1) >= count_q);

	// signed compare with direction
	always_comb begin
		if (asc_q)
			move = $signed(rdata_q) > $signed(v_q);
		else
			move = $signed(rdata_q) < $signed(v_q);
	end

	// sort: i walks 1..count-1, v is entry i, j walks down comparing entry j-1
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = rdata_q;
		raddr = '0;
		unique case (state_q)
			iiae_pkg::S_RD: begin
				// insert walks down and copies entry i-1 into i
				if (op_q == iiae_pkg::OP_INSERT)
					raddr = AW'(i_q - CW'(1));
				else
					raddr = AW'(i_q);
			end
			iiae_pkg::S_WAIT: raddr = AW'(i_q - CW'(1));
			iiae_pkg::S_EXEC: begin
				unique case (op_q)
					iiae_pkg::OP_INSERT: begin
						we = 1'b1;
						waddr = AW'(i_q);
					end
					iiae_pkg::OP_DELETE: begin
						we = 1'b1;
						waddr = AW'(i_q - CW'(1));
					end
					iiae_pkg::OP_SORT_UP, iiae_pkg::OP_SORT_DOWN: begin
						we = 1'b1;
						waddr = AW'(j_q);
						wdata = move ? rdata_q : v_q;
						// fetch the next neighbor while this one moves up
						raddr = AW'(j_q - CW'(2));
					end
					default: ;
				endcase
			end
			iiae_pkg::S_WB2: begin
				we = 1'b1;
				waddr = AW'(j_q);
				wdata = v_q;
			end
			iiae_pkg::S_WB: begin
				we = (op_q == iiae_pkg::OP_INSERT);
				waddr = AW'(pos_q);
				wdata = val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iiae_pkg::S_IDLE;
			op_q <= iiae_pkg::OP_INSERT;
			count_q <= '0;
			pos_q <= '0;
			i_q <= '0;
			j_q <= '0;
			val_q <= '0;
			v_q <= '0;
			done <= 1'b0;
			status_q <= iiae_pkg::ST_DONE;
			found_q <= 1'b0;
			asc_q <= 1'b0;
		end else begin
			done <= (state_q == iiae_pkg::S_DONE);
			unique case (state_q)
				iiae_pkg::S_IDLE: begin
					if (start && !busy) begin
						op_q <= iiae_pkg::op_t'(operation);
						pos_q <= pos_ext;
						val_q <= item_value;
						found_q <= 1'b0;
						asc_q <= (operation == iiae_pkg::OP_SORT_UP);
						unique case (operation)
							iiae_pkg::OP_INSERT: begin
								if (pos_big || pos_ext > count_q) begin
									status_q <= iiae_pkg::ST_BAD_INDEX;
									state_q <= iiae_pkg::S_DONE;
								end else if (count_q == DEPTH_C) begin
									status_q <= iiae_pkg::ST_FULL;
									state_q <= iiae_pkg::S_DONE;
								end else begin
									// move entries from count-1 down to pos up
									status_q <= iiae_pkg::ST_DONE;
									i_q <= count_q;
									state_q <= (count_q == pos_ext) ?
										iiae_pkg::S_WB : iiae_pkg::S_RD;
								end
							end
							iiae_pkg::OP_DELETE: begin
								if (pos_big || pos_ext >= count_q) begin
									status_q <= iiae_pkg::ST_BAD_INDEX;
									state_q <= iiae_pkg::S_DONE;
								end else begin
									status_q <= iiae_pkg::ST_DONE;
									i_q <= pos_ext + CW'(1);
									state_q <= (pos_ext + CW'(1) == count_q) ?
										iiae_pkg::S_WB : iiae_pkg::S_RD;
								end
							end
							iiae_pkg::OP_SORT_UP, iiae_pkg::OP_SORT_DOWN: begin
								status_q <= iiae_pkg::ST_DONE;
								i_q <= CW'(1);
								state_q <= (count_q > CW'(1)) ?
									iiae_pkg::S_RD : iiae_pkg::S_DONE;
							end
							iiae_pkg::OP_SEARCH: begin
								status_q <= iiae_pkg::ST_DONE;
								i_q <= '0;
								state_q <= (count_q != '0) ?
									iiae_pkg::S_RD : iiae_pkg::S_DONE;
							end
							default: begin
								status_q <= iiae_pkg::ST_DONE;
								state_q <= iiae_pkg::S_DONE;
							end
						endcase
					end
				end
				iiae_pkg::S_RD: begin
					if (op_q == iiae_pkg::OP_SORT_UP || op_q == iiae_pkg::OP_SORT_DOWN)
						state_q <= iiae_pkg::S_WAIT;
					else
						state_q <= iiae_pkg::S_EXEC;
				end
				iiae_pkg::S_WAIT: begin
					// rdata holds entry i, the value being placed
					v_q <= rdata_q;
					j_q <= i_q;
					state_q <= iiae_pkg::S_EXEC;
				end
				iiae_pkg::S_EXEC: begin
					unique case (op_q)
						iiae_pkg::OP_INSERT: begin
							if (i_q - CW'(1) == pos_q)
								state_q <= iiae_pkg::S_WB;
							else begin
								i_q <= i_q - CW'(1);
								state_q <= iiae_pkg::S_RD;
							end
						end
						iiae_pkg::OP_DELETE: begin
							if (i_q + CW'(1) == count_q)
								state_q <= iiae_pkg::S_WB;
							else begin
								i_q <= i_q + CW'(1);
								state_q <= iiae_pkg::S_RD;
							end
						end
						iiae_pkg::OP_SEARCH: begin
							if (rdata_q == val_q) begin
								found_q <= 1'b1;
								state_q <= iiae_pkg::S_DONE;
							end else if (i_q + CW'(1) == count_q)
								state_q <= iiae_pkg::S_DONE;
							else begin
								i_q <= i_q + CW'(1);
								state_q <= iiae_pkg::S_RD;
							end
						end
						iiae_pkg::OP_SORT_UP, iiae_pkg::OP_SORT_DOWN: begin
							if (move && j_q == CW'(1)) begin
								// reached the bottom, v goes to entry 0
								j_q <= '0;
								state_q <= iiae_pkg::S_WB2;
							end else if (move)
								j_q <= j_q - CW'(1);
							else if (last_i)
								state_q <= iiae_pkg::S_DONE;
							else begin
								i_q <= i_q + CW'(1);
								state_q <= iiae_pkg::S_RD;
							end
						end
						default: state_q <= iiae_pkg::S_DONE;
					endcase
				end
				iiae_pkg::S_WB2: begin
					if (last_i)
						state_q <= iiae_pkg::S_DONE;
					else begin
						i_q <= i_q + CW'(1);
						state_q <= iiae_pkg::S_RD;
					end
				end
				iiae_pkg::S_WB: begin
					if (op_q == iiae_pkg::OP_INSERT)
						count_q <= count_q + CW'(1);
					else
						count_q <= count_q - CW'(1);
					state_q <= iiae_pkg::S_DONE;
				end
				iiae_pkg::S_DONE: state_q <= iiae_pkg::S_IDLE;
				default: state_q <= iiae_pkg::S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != iiae_pkg::S_IDLE) || done;
	assign status = status_q;
	assign found = found_q;
	assign fill_count = 5'(count_q);

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C) else $error("fill count above depth");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result held more than one cycle");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("idle while result shown");
	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q != iiae_pkg::ST_DONE) |-> $stable(count_q))
		else $error("rejected operation changed count");
`endif

endmodule
